### hdl/vte_pkg.sv
// Shared types and constants of the voxel table editor.
// No dependencies.
`default_nettype none
package vte_pkg;
    localparam int TableDepth = 256;
    localparam int CoordBits = 10;
    localparam int IdxBits = $clog2(TableDepth);
    localparam int CntBits = IdxBits + 1;
    localparam int CellBits = 3 * CoordBits;

    localparam logic [2:0] CMD_QUERY = 3'd0;
    localparam logic [2:0] CMD_ADD = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_EDIT_COLOR = 3'd3;
    localparam logic [2:0] CMD_EDIT_TEX = 3'd4;
    localparam logic [2:0] CMD_EXTRUDE = 3'd5;
    localparam logic [2:0] CMD_DIG = 3'd6;

    localparam logic [2:0] ST_DONE = 3'd0;
    localparam logic [2:0] ST_OCCUPIED = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;

    localparam logic [1:0] KIND_GRASS = 2'd1;

    typedef struct packed {
        logic             hit;
        logic [IdxBits-1:0] idx;
    } scan_res_t;
endpackage
`default_nettype wire

### hdl/voxel_table_editor.sv
// Top level of the voxel table editor: stream ports around the sequencer.
// Depends on vte_pkg and vte_ctrl.
`default_nettype none
// One command at a time. A lookup reads the cell store one entry a cycle until
// a hit or the end of the fill; an item passes through lookup, decide, output,
// handshake and idle from one accept to the next, and a remove adds a move of
// the last entry into its hole. Extrude and dig repeat the lookup once per
// occupied cell of the column.
// The result is held on the master side until taken, then the next item is
// accepted. No clearing pass is needed after reset.
module voxel_table_editor import vte_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[2:0], pos_x[12:3], pos_y[22:13], pos_z[32:23], color[64:33],
    // tex_type[66:65], zero fill
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], found[3], slot[11:4], target_y[21:12], fill[30:22], zero fill
    output logic [31:0]      m_tdata
);
    logic [2:0] status;
    logic found;
    logic [7:0] slot;
    logic [CoordBits-1:0] target_y;
    logic [8:0] fill;

    vte_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tdata[2:0]), .in_x(s_tdata[12:3]), .in_y(s_tdata[22:13]),
        .in_z(s_tdata[32:23]), .in_color(s_tdata[64:33]), .in_tex(s_tdata[66:65]),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_status(status), .res_found(found), .res_slot(slot),
        .res_ty(target_y), .res_fill(fill));

    assign m_tdata = {1'b0, fill, target_y, slot, found, status};

    logic [4:0] unused_in;
    assign unused_in = s_tdata[71:67];
endmodule
`default_nettype wire

### hdl/vte_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none
module vte_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]              rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/vte_ctrl.sv
// Command sequencer: scans the cell store, walks columns, edits the stores.
// Depends on vte_pkg and vte_ram.
`default_nettype none
module vte_ctrl import vte_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [2:0]            in_cmd,
    input  wire logic [CoordBits-1:0]  in_x,
    input  wire logic [CoordBits-1:0]  in_y,
    input  wire logic [CoordBits-1:0]  in_z,
    input  wire logic [31:0]           in_color,
    input  wire logic [1:0]            in_tex,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic [2:0]                 res_status,
    output logic                       res_found,
    output logic [7:0]                 res_slot,
    output logic [CoordBits-1:0]       res_ty,
    output logic [8:0]                 res_fill
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_MOVE_R = 9'b000001000,
        S_MOVE_W = 9'b000010000,
        S_COLRD  = 9'b000100000,
        S_COLWT  = 9'b001000000,
        S_OUT    = 9'b010000000,
        S_WAIT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] cmd_reg;
    logic [CoordBits-1:0] x_reg, z_reg, y0_reg, cy_reg;
    logic [31:0] col_reg;
    logic [1:0] tex_reg, kind_reg;
    logic [CntBits-1:0] cnt_reg;
    // Scan pointer: address issued and address whose data is now on the read port.
    logic [CntBits-1:0] ptr_reg;
    logic rd_v_reg;
    logic [IdxBits-1:0] rd_a_reg;
    scan_res_t hit_reg;
    // Walk phase: 0 first lookup at y0, 1 walking upward, 2 dig target lookup.
    logic [1:0] phase_reg;
    logic found0_reg;
    logic [IdxBits-1:0] idx0_reg;

    logic [2:0] st_reg;
    logic fd_reg;
    logic [IdxBits-1:0] sl_reg;
    logic [CoordBits-1:0] ty_reg;

    logic [IdxBits-1:0] mv_dst_reg;

    logic cell_we, colr_we, tex_we;
    logic [IdxBits-1:0] cell_wa, colr_wa, tex_wa, cell_ra, side_ra;
    logic [CellBits-1:0] cell_wd, cell_rd;
    logic [31:0] colr_wd, colr_rd;
    logic [1:0] tex_wd, tex_rd;

    logic [CellBits-1:0] key;
    logic [IdxBits-1:0] last_idx;
    logic full;

    assign key = {x_reg, cy_reg, z_reg};
    assign last_idx = cnt_reg[IdxBits-1:0] - 1'b1;
    assign full = cnt_reg[CntBits-1];
    assign in_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_WAIT);
    assign res_status = st_reg;
    assign res_found = fd_reg;
    assign res_slot = 8'(sl_reg);
    assign res_ty = ty_reg;
    assign res_fill = 9'(cnt_reg);

    vte_ram #(.Width(CellBits), .Depth(TableDepth)) u_cell (
        .clk(clk), .we(cell_we), .waddr(cell_wa), .wdata(cell_wd),
        .raddr(cell_ra), .rdata(cell_rd));
    vte_ram #(.Width(32), .Depth(TableDepth)) u_colr (
        .clk(clk), .we(colr_we), .waddr(colr_wa), .wdata(colr_wd),
        .raddr(side_ra), .rdata(colr_rd));
    vte_ram #(.Width(2), .Depth(TableDepth)) u_tex (
        .clk(clk), .we(tex_we), .waddr(tex_wa), .wdata(tex_wd),
        .raddr(side_ra), .rdata(tex_rd));

    // The last entry is read on all three stores while a removal fills its hole.
    assign cell_ra = (state_reg == S_MOVE_R) ? last_idx : ptr_reg[IdxBits-1:0];
    assign side_ra = (state_reg == S_MOVE_R) ? last_idx : idx0_reg;

    logic scan_hit;
    assign scan_hit = rd_v_reg && (cell_rd == key);

    // Next column y and range checks for the walk.
    logic [CoordBits-1:0] cy_inc, cy_dec;
    logic at_top;
    assign cy_inc = cy_reg + 1'b1;
    assign cy_dec = cy_reg - 1'b1;
    assign at_top = (cy_reg == {1'b0, {(CoordBits-1){1'b1}}});

    always_comb
    begin
        state_next = state_reg;
        cell_we = 1'b0;
        colr_we = 1'b0;
        tex_we = 1'b0;
        cell_wa = cnt_reg[IdxBits-1:0];
        colr_wa = cnt_reg[IdxBits-1:0];
        tex_wa = cnt_reg[IdxBits-1:0];
        cell_wd = key;
        colr_wd = col_reg;
        tex_wd = tex_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_hit || (!rd_v_reg && ptr_reg >= cnt_reg))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_OUT;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (!hit_reg.hit && !full)
                        begin
                            cell_we = 1'b1;
                            colr_we = 1'b1;
                            tex_we = 1'b1;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (hit_reg.hit)
                        begin
                            state_next = S_MOVE_R;
                        end
                    end
                    CMD_EDIT_COLOR:
                    begin
                        colr_wa = hit_reg.idx;
                        colr_we = hit_reg.hit;
                    end
                    CMD_EDIT_TEX:
                    begin
                        tex_wa = hit_reg.idx;
                        tex_we = hit_reg.hit;
                    end
                    CMD_EXTRUDE, CMD_DIG:
                    begin
                        if (phase_reg == 2'd0 && hit_reg.hit && cmd_reg == CMD_EXTRUDE
                            && !at_top)
                        begin
                            state_next = S_COLRD;
                        end
                        else if (phase_reg == 2'd2)
                        begin
                            if (hit_reg.hit)
                            begin
                                state_next = S_MOVE_R;
                            end
                        end
                        else if (hit_reg.hit && !at_top)
                        begin
                            state_next = S_SCAN;
                        end
                        else if (cmd_reg == CMD_EXTRUDE)
                        begin
                            if (!hit_reg.hit && !full)
                            begin
                                cell_we = 1'b1;
                                colr_we = 1'b1;
                                tex_we = 1'b1;
                                tex_wd = kind_reg;
                            end
                        end
                        else if (!(hit_reg.hit && at_top) && cy_reg == y0_reg
                                 && y0_reg == {1'b1, {(CoordBits-1){1'b0}}})
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_COLRD: state_next = S_COLWT;
            S_COLWT: state_next = S_SCAN;
            S_MOVE_R: state_next = S_MOVE_W;
            S_MOVE_W:
            begin
                cell_we = 1'b1;
                colr_we = 1'b1;
                tex_we = 1'b1;
                cell_wa = mv_dst_reg;
                colr_wa = mv_dst_reg;
                tex_wa = mv_dst_reg;
                cell_wd = cell_rd;
                colr_wd = colr_rd;
                tex_wd = tex_rd;
                state_next = S_OUT;
            end
            S_OUT: state_next = S_WAIT;
            S_WAIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            kind_reg <= KIND_GRASS;
            rd_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg <= in_cmd;
                        x_reg <= in_x;
                        y0_reg <= in_y;
                        cy_reg <= in_y;
                        z_reg <= in_z;
                        col_reg <= in_color;
                        tex_reg <= in_tex;
                        ptr_reg <= '0;
                        hit_reg <= '0;
                        phase_reg <= 2'd0;
                        found0_reg <= 1'b0;
                        idx0_reg <= '0;
                        st_reg <= ST_DONE;
                        fd_reg <= 1'b0;
                        sl_reg <= '0;
                        ty_reg <= '0;
                        if (in_cmd == CMD_EDIT_TEX)
                        begin
                            kind_reg <= in_tex;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (scan_hit)
                    begin
                        hit_reg.hit <= 1'b1;
                        hit_reg.idx <= rd_a_reg;
                    end
                    else if (ptr_reg < cnt_reg)
                    begin
                        rd_v_reg <= 1'b1;
                        rd_a_reg <= ptr_reg[IdxBits-1:0];
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                S_DECIDE:
                begin
                    ptr_reg <= '0;
                    case (cmd_reg)
                        CMD_QUERY, CMD_REMOVE, CMD_EDIT_COLOR, CMD_EDIT_TEX:
                        begin
                            fd_reg <= hit_reg.hit;
                            sl_reg <= hit_reg.hit ? hit_reg.idx : '0;
                            st_reg <= hit_reg.hit ? ST_DONE : ST_NOT_FOUND;
                            mv_dst_reg <= hit_reg.idx;
                        end
                        CMD_ADD:
                        begin
                            fd_reg <= hit_reg.hit;
                            if (hit_reg.hit)
                            begin
                                st_reg <= ST_OCCUPIED;
                                sl_reg <= hit_reg.idx;
                            end
                            else if (full)
                            begin
                                st_reg <= ST_FULL;
                            end
                            else
                            begin
                                sl_reg <= cnt_reg[IdxBits-1:0];
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (cmd_reg == CMD_EXTRUDE || cmd_reg == CMD_DIG)
                    begin
                        hit_reg <= '0;
                        if (phase_reg == 2'd0)
                        begin
                            found0_reg <= hit_reg.hit;
                            fd_reg <= (cmd_reg == CMD_EXTRUDE) && hit_reg.hit;
                            idx0_reg <= hit_reg.idx;
                        end
                        if (phase_reg == 2'd2)
                        begin
                            ty_reg <= cy_reg;
                            fd_reg <= hit_reg.hit;
                            sl_reg <= hit_reg.hit ? hit_reg.idx : '0;
                            st_reg <= hit_reg.hit ? ST_DONE : ST_NOT_FOUND;
                            mv_dst_reg <= hit_reg.idx;
                        end
                        else if (hit_reg.hit && !at_top)
                        begin
                            if (!(phase_reg == 2'd0 && cmd_reg == CMD_EXTRUDE))
                            begin
                                cy_reg <= cy_inc;
                            end
                            phase_reg <= 2'd1;
                        end
                        else if (cmd_reg == CMD_EXTRUDE)
                        begin
                            if (hit_reg.hit)
                            begin
                                st_reg <= ST_RANGE;
                            end
                            else if (full)
                            begin
                                st_reg <= ST_FULL;
                                ty_reg <= cy_reg;
                            end
                            else
                            begin
                                ty_reg <= cy_reg;
                                sl_reg <= cnt_reg[IdxBits-1:0];
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            // Dig: target is the cell below the first free one, or the top cell.
                            phase_reg <= 2'd2;
                            if (hit_reg.hit)
                            begin
                                cy_reg <= cy_reg;
                            end
                            else if (cy_reg == y0_reg
                                     && y0_reg == {1'b1, {(CoordBits-1){1'b0}}})
                            begin
                                st_reg <= ST_RANGE;
                            end
                            else
                            begin
                                cy_reg <= cy_dec;
                            end
                        end
                    end
                end
                S_COLWT:
                begin
                    // Extrude takes the start voxel's colour, then resumes the walk.
                    col_reg <= colr_rd;
                    cy_reg <= cy_inc;
                    phase_reg <= 2'd1;
                    hit_reg <= '0;
                    ptr_reg <= '0;
                end
                S_MOVE_W:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    logic unused_found0;
    assign unused_found0 = found0_reg;
endmodule
`default_nettype wire

### hdl/vte_checker.sv
// Port-level checks of the voxel table editor, bound to the top level.
// Depends on voxel_table_editor ports only.
`default_nettype none
module vte_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("input taken while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= 3'd4) else $error("bad status");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[30:22] <= 9'd256) else $error("fill overflow");
endmodule

bind voxel_table_editor vte_checker u_vte_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
`default_nettype wire

### bench/tb_voxel_table_editor.sv
// Self-checking testbench of the voxel table editor: directed table, random commands, then a fill to capacity.
// Depends on vte_pkg and voxel_table_editor; results are checked against a built-in predictor.
`timescale 1ns / 100ps
module tb_voxel_table_editor;
    import vte_pkg::*;

    localparam int CoordMax = (1 << (CoordBits - 1)) - 1;
    localparam int CoordMin = -(1 << (CoordBits - 1));

    typedef struct packed {
        logic [2:0]           cmd;
        logic [CoordBits-1:0] x;
        logic [CoordBits-1:0] y;
        logic [CoordBits-1:0] z;
        logic [31:0]          color;
        logic [1:0]           tex;
    } voxel_cmd_t;

    typedef struct packed {
        logic [2:0]           status;
        logic                 found;
        logic [7:0]           slot;
        logic [CoordBits-1:0] target_y;
        logic [8:0]           fill;
    } voxel_res_t;

    typedef struct packed {
        voxel_cmd_t c;
        logic       typed;
        voxel_res_t r;
    } dir_row_t;

    // Rows with typed set carry the expected result; the rest use the predictor.
    localparam int NumDir = 24;
    localparam dir_row_t DIR_ROWS [NumDir] = '{
        '{'{CMD_QUERY, 10'd0, 10'd0, 10'd0, 32'h0, 2'd0}, 1'b1,
          '{ST_NOT_FOUND, 1'b0, 8'd0, 10'd0, 9'd0}},
        '{'{CMD_DIG, 10'd0, 10'd0, 10'd0, 32'h0, 2'd0}, 1'b1,
          '{ST_NOT_FOUND, 1'b0, 8'd0, 10'h3FF, 9'd0}},
        '{'{CMD_DIG, 10'd5, 10'h200, 10'd5, 32'h0, 2'd0}, 1'b1,
          '{ST_RANGE, 1'b0, 8'd0, 10'd0, 9'd0}},
        '{'{CMD_ADD, 10'd0, 10'd0, 10'd0, 32'hFFFFFFFF, 2'd3}, 1'b1,
          '{ST_DONE, 1'b0, 8'd0, 10'd0, 9'd1}},
        '{'{CMD_ADD, 10'd0, 10'd0, 10'd0, 32'h0, 2'd1}, 1'b1,
          '{ST_OCCUPIED, 1'b1, 8'd0, 10'd0, 9'd1}},
        '{'{CMD_ADD, 10'h200, 10'h200, 10'h200, 32'h0, 2'd0}, 1'b1,
          '{ST_DONE, 1'b0, 8'd1, 10'd0, 9'd2}},
        '{'{CMD_ADD, 10'h1FF, 10'h1FF, 10'h1FF, 32'hA5A5A5A5, 2'd2}, 1'b1,
          '{ST_DONE, 1'b0, 8'd2, 10'd0, 9'd3}},
        '{'{CMD_EDIT_COLOR, 10'd0, 10'd0, 10'd0, 32'h12345678, 2'd0}, 1'b1,
          '{ST_DONE, 1'b1, 8'd0, 10'd0, 9'd3}},
        '{'{CMD_EDIT_COLOR, 10'd1, 10'd1, 10'd1, 32'h5A5A5A5A, 2'd0}, 1'b1,
          '{ST_NOT_FOUND, 1'b0, 8'd0, 10'd0, 9'd3}},
        '{'{CMD_EDIT_TEX, 10'd0, 10'd0, 10'd0, 32'h0, 2'd2}, 1'b1,
          '{ST_DONE, 1'b1, 8'd0, 10'd0, 9'd3}},
        '{'{CMD_EDIT_TEX, 10'd1, 10'd2, 10'd3, 32'h0, 2'd3}, 1'b1,
          '{ST_NOT_FOUND, 1'b0, 8'd0, 10'd0, 9'd3}},
        '{'{CMD_EXTRUDE, 10'd0, 10'd0, 10'd0, 32'hDEADBEEF, 2'd0}, 1'b0, '0},
        '{'{CMD_EXTRUDE, 10'd2, 10'd0, 10'd2, 32'hCAFEF00D, 2'd1}, 1'b0, '0},
        '{'{CMD_ADD, 10'd7, 10'h1FD, 10'd7, 32'h01020304, 2'd1}, 1'b0, '0},
        '{'{CMD_ADD, 10'd7, 10'h1FE, 10'd7, 32'h05060708, 2'd2}, 1'b0, '0},
        '{'{CMD_ADD, 10'd7, 10'h1FF, 10'd7, 32'h090A0B0C, 2'd3}, 1'b0, '0},
        '{'{CMD_EXTRUDE, 10'd7, 10'h1FD, 10'd7, 32'h0, 2'd0}, 1'b0, '0},
        '{'{CMD_DIG, 10'd7, 10'h1FD, 10'd7, 32'h0, 2'd0}, 1'b0, '0},
        '{'{CMD_DIG, 10'd0, 10'd0, 10'd0, 32'h0, 2'd0}, 1'b0, '0},
        '{'{CMD_REMOVE, 10'd0, 10'd0, 10'd0, 32'h0, 2'd0}, 1'b0, '0},
        '{'{CMD_REMOVE, 10'd3, 10'd3, 10'd3, 32'h0, 2'd0}, 1'b0, '0},
        '{'{CMD_QUERY, 10'h1FF, 10'h1FF, 10'h1FF, 32'h0, 2'd0}, 1'b0, '0},
        '{'{3'd7, 10'h155, 10'h2AA, 10'h155, 32'hFFFF0000, 2'd3}, 1'b0, '0},
        '{'{CMD_QUERY, 10'h200, 10'h200, 10'h200, 32'h0, 2'd0}, 1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    // Predictor copy of the table.
    logic [CellBits-1:0] cells [TableDepth];
    logic [31:0]         colors [TableDepth];
    logic [1:0]          kinds [TableDepth];
    int                  voxel_total;
    logic [1:0]          cur_kind;

    voxel_res_t pending_results [$];
    int         errors = 0;
    int         results_seen = 0;
    bit         stim_done;
    int         burst_left;

    voxel_table_editor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int find_cell(input logic [CellBits-1:0] key);
        for (int i = 0; i < voxel_total; i++)
        begin
            if (cells[i] == key)
                return i;
        end
        return -1;
    endfunction

    // First free y at or above y0 in the column; may be one past the top.
    function automatic int climb(input logic [CoordBits-1:0] x, input logic [CoordBits-1:0] y0,
                                 input logic [CoordBits-1:0] z);
        int y;
        logic [CoordBits-1:0] yb;
        y = int'($signed(y0));
        yb = y[CoordBits-1:0];
        while (y <= CoordMax && find_cell({x, yb, z}) >= 0)
        begin
            y++;
            yb = y[CoordBits-1:0];
        end
        return y;
    endfunction

    task automatic drop_voxel(input int idx);
        int last;
        last = voxel_total - 1;
        cells[idx] = cells[last];
        colors[idx] = colors[last];
        kinds[idx] = kinds[last];
        voxel_total = last;
    endtask

    task automatic append_voxel(input logic [CellBits-1:0] key, input logic [31:0] col,
                                input logic [1:0] kind, output logic [7:0] slot);
        slot = voxel_total[7:0];
        cells[voxel_total] = key;
        colors[voxel_total] = col;
        kinds[voxel_total] = kind;
        voxel_total++;
    endtask

    task automatic predict_edit(input voxel_cmd_t c, output voxel_res_t r);
        int idx;
        int yt;
        int k;
        logic [31:0] col;
        idx = find_cell({c.x, c.y, c.z});
        r = '0;
        case (c.cmd)
            CMD_QUERY:
            begin
                if (idx >= 0)
                begin
                    r.found = 1'b1;
                    r.slot = idx[7:0];
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            CMD_ADD:
            begin
                if (idx >= 0)
                begin
                    r.status = ST_OCCUPIED;
                    r.found = 1'b1;
                    r.slot = idx[7:0];
                end
                else if (voxel_total >= TableDepth)
                    r.status = ST_FULL;
                else
                    append_voxel({c.x, c.y, c.z}, c.color, c.tex, r.slot);
            end
            CMD_REMOVE, CMD_EDIT_COLOR, CMD_EDIT_TEX:
            begin
                if (c.cmd == CMD_EDIT_TEX)
                    cur_kind = c.tex;
                if (idx >= 0)
                begin
                    r.found = 1'b1;
                    r.slot = idx[7:0];
                    if (c.cmd == CMD_REMOVE)
                        drop_voxel(idx);
                    else if (c.cmd == CMD_EDIT_COLOR)
                        colors[idx] = c.color;
                    else
                        kinds[idx] = c.tex;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            CMD_EXTRUDE:
            begin
                col = c.color;
                if (idx >= 0)
                begin
                    r.found = 1'b1;
                    col = colors[idx];
                end
                yt = climb(c.x, c.y, c.z);
                if (yt > CoordMax)
                    r.status = ST_RANGE;
                else if (voxel_total >= TableDepth)
                begin
                    r.status = ST_FULL;
                    r.target_y = yt[CoordBits-1:0];
                end
                else
                begin
                    r.target_y = yt[CoordBits-1:0];
                    append_voxel({c.x, yt[CoordBits-1:0], c.z}, col, cur_kind, r.slot);
                end
            end
            CMD_DIG:
            begin
                yt = climb(c.x, c.y, c.z) - 1;
                if (yt < CoordMin)
                    r.status = ST_RANGE;
                else
                begin
                    r.target_y = yt[CoordBits-1:0];
                    k = find_cell({c.x, yt[CoordBits-1:0], c.z});
                    if (k >= 0)
                    begin
                        r.found = 1'b1;
                        r.slot = k[7:0];
                        drop_voxel(k);
                    end
                    else
                        r.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
        r.fill = voxel_total[8:0];
    endtask

    // Offers one item, waits for it to be taken, then maybe opens a gap.
    task automatic issue_cmd(input voxel_cmd_t c, input logic typed, input voxel_res_t typed_res);
        voxel_res_t r;
        int gap;
        predict_edit(c, r);
        if (typed)
            r = typed_res;
        s_tdata <= {5'd0, c.tex, c.color, c.z, c.y, c.x, c.cmd};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results = {pending_results, r};
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic logic [CoordBits-1:0] pick_coord(input int lo, input int hi);
        int v;
        if ($urandom_range(9) == 0)
            v = $urandom;
        else
            v = lo + $urandom_range(hi - lo);
        return v[CoordBits-1:0];
    endfunction

    function automatic voxel_cmd_t random_cmd();
        voxel_cmd_t c;
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            c.cmd = CMD_ADD;
        else if (pick < 45)
            c.cmd = CMD_EXTRUDE;
        else if (pick < 60)
            c.cmd = CMD_DIG;
        else if (pick < 70)
            c.cmd = CMD_QUERY;
        else if (pick < 80)
            c.cmd = CMD_REMOVE;
        else if (pick < 88)
            c.cmd = CMD_EDIT_COLOR;
        else if (pick < 97)
            c.cmd = CMD_EDIT_TEX;
        else
            c.cmd = 3'd7;
        c.x = pick_coord(-2, 2);
        c.y = pick_coord(-2, 3);
        c.z = pick_coord(-2, 2);
        c.color = $urandom;
        c.tex = $urandom_range(3);
        return c;
    endfunction

    initial
    begin
        voxel_cmd_t c;
        int k;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        voxel_total = 0;
        cur_kind = KIND_GRASS;
        stim_done = 1'b0;
        burst_left = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NumDir; i++)
            issue_cmd(DIR_ROWS[i].c, DIR_ROWS[i].typed, DIR_ROWS[i].r);

        for (int i = 0; i < 300; i++)
            issue_cmd(random_cmd(), 1'b0, '0);

        // Fill the table to the brim in a separate region, then push past it.
        k = 0;
        while (voxel_total < TableDepth && k < 600)
        begin
            c.cmd = CMD_ADD;
            c.x = 10'(100 + k % 32);
            c.y = 10'd50;
            c.z = 10'(100 + k / 32);
            c.color = $urandom;
            c.tex = $urandom_range(3);
            issue_cmd(c, 1'b0, '0);
            k++;
        end
        for (int i = 0; i < 40; i++)
        begin
            c = random_cmd();
            c.x = 10'(100 + $urandom_range(40));
            c.y = 10'(49 + $urandom_range(2));
            c.z = 10'(100 + $urandom_range(10));
            issue_cmd(c, 1'b0, '0);
        end
        stim_done = 1'b1;
        s_tvalid <= 1'b0;
    end

    // Receiver: random stalls with calm stretches, and one long hold-off.
    initial
    begin
        bit held;
        int mode_left;
        int mode;
        m_tready = 1'b0;
        held = 1'b0;
        mode_left = 0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= 60)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            if (mode_left <= 0)
            begin
                mode = $urandom_range(2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (mode == 0)
                m_tready <= 1'b1;
            else if (mode == 1)
                m_tready <= ($urandom_range(3) != 0);
            else
                m_tready <= ($urandom_range(3) == 0);
        end
    end

    always @(posedge clk)
    begin
        voxel_res_t got;
        voxel_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tdata[2:0];
            got.found = m_tdata[3];
            got.slot = m_tdata[11:4];
            got.target_y = m_tdata[21:12];
            got.fill = m_tdata[30:22];
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.found !== want.found ||
                    got.slot !== want.slot || got.target_y !== want.target_y ||
                    got.fill !== want.fill)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("exp/got st %0d/%0d fd %0d/%0d sl %0d/%0d ty %h/%h fl %0d/%0d",
                                 want.status, got.status, want.found, got.found,
                                 want.slot, got.slot, want.target_y, got.target_y,
                                 want.fill, got.fill);
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        wait (pending_results.size() == 0);
        repeat (2000) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

### voxel_table_editor.f
hdl/vte_pkg.sv
hdl/vte_ram.sv
hdl/vte_ctrl.sv
hdl/voxel_table_editor.sv
hdl/vte_checker.sv
bench/tb_voxel_table_editor.sv
